// ===== hw/rtl/sac_pkg.sv =====
package sac_pkg;

    localparam int LINE_BYTES = 64;
    localparam int SETS       = 128;
    localparam int WAYS       = 8;

    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int SET_W   = $clog2(SETS);
    localparam int WAY_W   = $clog2(WAYS);
    localparam int TAG_W   = 32 - OFF_W - SET_W;
    localparam int WORDS   = LINE_BYTES / 4;
    localparam int WORD_W  = $clog2(WORDS);
    localparam int TENT_W  = TAG_W + 1;
    localparam int TROW_W  = WAYS * TENT_W;
    localparam int DROW_W  = WAYS * 32;
    localparam int DDEPTH  = SETS * WORDS;
    localparam int TDATA_W = 72;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_REFILL = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [2:0]  len;
        logic [31:0] data;
        logic        last;
    } result_t;

endpackage

// ===== hw/rtl/sac_ram.sv =====
module sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sac_ctrl.sv =====
module sac_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sac_pkg::TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                    s_tuser,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    input  logic                          out_space,
    output sac_pkg::result_t              res
);

    typedef enum logic [2:0] {ST_IDLE, ST_LOOK, ST_CHECK, ST_WAIT, ST_FILL} state_t;

    state_t                          state_reg;
    logic                            is_write_reg;
    logic                            cross_reg;
    logic [31:0]                     addr_reg;
    logic [2:0]                      len_reg;
    logic [31:0]                     pay_reg;
    logic [31:0]                     bytes_reg;
    logic [2:0]                      done_reg;
    logic [31:0]                     cur_reg;
    logic [sac_pkg::SET_W-1:0]       set_reg;
    logic [sac_pkg::TAG_W-1:0]       tag_reg;
    logic [sac_pkg::OFF_W-1:0]       off_reg;
    logic [sac_pkg::WAY_W-1:0]       way_reg;
    logic [sac_pkg::WORD_W-1:0]      cnt_reg;
    logic [sac_pkg::TROW_W-1:0]      trow_reg;
    logic [15:0]                     lfsr_reg;
    logic [sac_pkg::SETS-1:0]        init_reg;

    logic [31:0]                     in_addr;
    logic [2:0]                      in_len_raw;
    logic [2:0]                      in_len;
    logic [31:0]                     in_pay;
    logic [sac_pkg::OFF_W:0]         in_end;
    logic                            accept;

    logic [31:0]                     cur_addr;
    logic                            tag_re;
    logic                            tag_we;
    logic [sac_pkg::SET_W-1:0]       tag_raddr;
    logic [sac_pkg::TROW_W-1:0]      tag_wdata;
    logic [sac_pkg::TROW_W-1:0]      tag_rdata;
    logic                            dat_re;
    logic                            dat_we;
    logic [sac_pkg::SET_W+sac_pkg::WORD_W-1:0] dat_raddr;
    logic [sac_pkg::SET_W+sac_pkg::WORD_W-1:0] dat_waddr;
    logic [sac_pkg::DROW_W-1:0]      dat_wdata;
    logic [sac_pkg::DROW_W-1:0]      dat_rdata;

    logic [sac_pkg::WAYS-1:0]        way_valid;
    logic                            hit;
    logic [sac_pkg::WAY_W-1:0]       hit_way;
    logic                            any_inv;
    logic [sac_pkg::WAY_W-1:0]       inv_way;
    logic [sac_pkg::WAY_W-1:0]       victim;
    logic [sac_pkg::TROW_W-1:0]      trow_miss;
    logic [sac_pkg::TROW_W-1:0]      trow_fill;
    logic [31:0]                     hit_word;
    logic [7:0]                      rbyte;
    logic [7:0]                      wbyte;
    logic [31:0]                     bytes_next;
    logic [31:0]                     wmask;
    logic                            last_byte;
    logic                            need_emit;
    logic                            go;
    logic [15:0]                     lfsr_next;

    assign in_addr    = s_tdata[31:0];
    assign in_len_raw = s_tdata[34:32];
    assign in_pay     = s_tdata[66:35];
    assign in_len     = (in_len_raw == 3'd0) ? 3'd1 : ((in_len_raw > 3'd4) ? 3'd4 : in_len_raw);
    assign in_end     = {1'b0, in_addr[sac_pkg::OFF_W-1:0]} + (sac_pkg::OFF_W+1)'(in_len);

    assign s_tready = (state_reg == ST_IDLE) || (state_reg == ST_WAIT);
    assign accept   = s_tvalid && s_tready;

    assign cur_addr = addr_reg + {29'd0, done_reg};

    assign tag_re    = (state_reg == ST_LOOK);
    assign tag_raddr = cur_addr[sac_pkg::OFF_W +: sac_pkg::SET_W];
    assign dat_re    = (state_reg == ST_LOOK) || (state_reg == ST_WAIT);
    assign dat_raddr = (state_reg == ST_WAIT) ? {set_reg, cnt_reg}
                     : {cur_addr[sac_pkg::OFF_W +: sac_pkg::SET_W],
                        cur_addr[2 +: sac_pkg::WORD_W]};

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = sac_pkg::WAYS - 1; w >= 0; w--) begin
            way_valid[w] = init_reg[set_reg] && tag_rdata[w*sac_pkg::TENT_W + sac_pkg::TAG_W];
            if (way_valid[w] &&
                tag_rdata[w*sac_pkg::TENT_W +: sac_pkg::TAG_W] == tag_reg) begin
                hit     = 1'b1;
                hit_way = sac_pkg::WAY_W'(w);
            end
            if (!way_valid[w]) begin
                any_inv = 1'b1;
                inv_way = sac_pkg::WAY_W'(w);
            end
        end
    end

    assign victim    = any_inv ? inv_way : lfsr_reg[sac_pkg::WAY_W-1:0];
    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ sac_pkg::LFSR_TAPS) : (lfsr_reg >> 1);

    always_comb begin
        trow_miss = tag_rdata;
        trow_fill = trow_reg;
        for (int w = 0; w < sac_pkg::WAYS; w++) begin
            trow_miss[w*sac_pkg::TENT_W + sac_pkg::TAG_W] =
                way_valid[w] && (sac_pkg::WAY_W'(w) != victim);
            if (sac_pkg::WAY_W'(w) == way_reg) begin
                trow_fill[w*sac_pkg::TENT_W +: sac_pkg::TENT_W] = {1'b1, tag_reg};
            end
        end
    end

    assign hit_word   = dat_rdata[{hit_way, 5'd0} +: 32];
    assign rbyte      = hit_word[{off_reg[1:0], 3'd0} +: 8];
    assign wbyte      = pay_reg[{done_reg[1:0], 3'd0} +: 8];
    assign bytes_next = bytes_reg | ({24'd0, rbyte} << {done_reg[1:0], 3'd0});
    assign last_byte  = ({1'b0, done_reg} + 4'd1) == {1'b0, len_reg};

    always_comb begin
        case (len_reg)
            3'd1:    wmask = 32'h0000_00FF;
            3'd2:    wmask = 32'h0000_FFFF;
            3'd3:    wmask = 32'h00FF_FFFF;
            default: wmask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        if (is_write_reg) begin
            need_emit = cross_reg || last_byte;
        end else begin
            need_emit = !hit || last_byte;
        end
    end

    assign go = (state_reg == ST_CHECK) && (!need_emit || out_space);

    always_comb begin
        res       = '0;
        res.valid = go && need_emit;
        res.last  = 1'b1;
        if (is_write_reg) begin
            res.kind = sac_pkg::KIND_WRITE;
            if (cross_reg) begin
                res.addr = cur_reg;
                res.len  = 3'd1;
                res.data = {24'd0, wbyte};
                res.last = last_byte;
            end else begin
                res.addr = addr_reg;
                res.len  = len_reg;
                res.data = pay_reg & wmask;
            end
        end else if (hit) begin
            res.kind = sac_pkg::KIND_READ;
            res.data = bytes_next;
        end else begin
            res.kind = sac_pkg::KIND_REFILL;
            res.addr = {cur_reg[31:sac_pkg::OFF_W], {sac_pkg::OFF_W{1'b0}}};
        end
    end

    always_comb begin
        tag_we    = 1'b0;
        tag_wdata = trow_miss;
        dat_we    = 1'b0;
        dat_waddr = {set_reg, off_reg[sac_pkg::OFF_W-1:2]};
        dat_wdata = dat_rdata;
        if (state_reg == ST_FILL) begin
            dat_we    = 1'b1;
            dat_waddr = {set_reg, cnt_reg};
            dat_wdata[{way_reg, 5'd0} +: 32] = pay_reg;
            tag_we    = (cnt_reg == sac_pkg::WORD_W'(sac_pkg::WORDS - 1));
            tag_wdata = trow_fill;
        end else if (go) begin
            if (is_write_reg) begin
                dat_we = hit;
                dat_wdata[{hit_way, off_reg[1:0], 3'd0} +: 8] = wbyte;
            end else begin
                tag_we = !hit;
            end
        end
    end

    sac_ram #(.WIDTH(sac_pkg::TROW_W), .DEPTH(sac_pkg::SETS)) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_we),
        .wr_addr (set_reg),
        .wr_data (tag_wdata),
        .rd_en   (tag_re),
        .rd_addr (tag_raddr),
        .rd_data (tag_rdata)
    );

    sac_ram #(.WIDTH(sac_pkg::DROW_W), .DEPTH(sac_pkg::DDEPTH)) u_data_ram (
        .aclk    (aclk),
        .wr_en   (dat_we),
        .wr_addr (dat_waddr),
        .wr_data (dat_wdata),
        .rd_en   (dat_re),
        .rd_addr (dat_raddr),
        .rd_data (dat_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lfsr_reg  <= 16'd1;
            init_reg  <= '0;
            len_reg   <= '0;
            done_reg  <= '0;
            cnt_reg   <= '0;
            way_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                lfsr_reg <= (cfg_wr_data == 16'd0) ? 16'd1 : cfg_wr_data;
            end else if (go && !is_write_reg && !hit && !any_inv) begin
                lfsr_reg <= lfsr_next;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_tuser == sac_pkg::OP_READ || s_tuser == sac_pkg::OP_WRITE)) begin
                        is_write_reg <= (s_tuser == sac_pkg::OP_WRITE);
                        cross_reg    <= in_end > (sac_pkg::OFF_W+1)'(sac_pkg::LINE_BYTES);
                        addr_reg     <= in_addr;
                        len_reg      <= in_len;
                        pay_reg      <= in_pay;
                        bytes_reg    <= '0;
                        done_reg     <= '0;
                        state_reg    <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    cur_reg   <= cur_addr;
                    set_reg   <= cur_addr[sac_pkg::OFF_W +: sac_pkg::SET_W];
                    tag_reg   <= cur_addr[31 -: sac_pkg::TAG_W];
                    off_reg   <= cur_addr[sac_pkg::OFF_W-1:0];
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (go) begin
                        if (!is_write_reg && !hit) begin
                            init_reg[set_reg] <= 1'b1;
                            trow_reg          <= trow_miss;
                            way_reg           <= victim;
                            cnt_reg           <= '0;
                            state_reg         <= ST_WAIT;
                        end else begin
                            bytes_reg <= bytes_next;
                            done_reg  <= done_reg + 3'd1;
                            state_reg <= last_byte ? ST_IDLE : ST_LOOK;
                        end
                    end
                end
                ST_WAIT: begin
                    if (accept && s_tuser == sac_pkg::OP_FILL) begin
                        pay_reg   <= in_pay;
                        state_reg <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == sac_pkg::WORD_W'(sac_pkg::WORDS - 1)) begin
                        state_reg <= ST_LOOK;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    ap_emit_space: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> out_space)
        else $error("result pushed into a full output register");

    ap_no_tag_write_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |-> !tag_we && !dat_we)
        else $error("array written while waiting for a refill word");

    ap_done_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK || state_reg == ST_CHECK) |-> (done_reg < len_reg))
        else $error("byte counter beyond access length");

    ap_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != 16'd0)
        else $error("replacement lfsr reached zero");

    ap_fill_resumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && cnt_reg == sac_pkg::WORD_W'(sac_pkg::WORDS - 1))
        |=> (state_reg == ST_LOOK))
        else $error("last refill word did not resume the read");

endmodule

// ===== hw/rtl/set_assoc_write_through_cache.sv =====
// channel   direction  tvalid/tready       tuser        tdata / tlast
// s_        request    s_tvalid/s_tready   op           address, length, payload
// m_        result     m_tvalid/m_tready   kind         mem_address, mem_length, result_data; last
// cfg_      register   cfg_wr_en           -            replace_seed
//
// Each access byte takes two steps (tag and data read, then compare and update);
// each result is then shown from a registered output stage.
// A read miss adds a refill request and, per refill word (16 words), a wait and a write step.
// Reset clears the per-set valid flags at once; there is no clearing pass.
// A full output register stalls only the step that has a result to push;
// requests are still accepted while a result waits.
module set_assoc_write_through_cache (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sac_pkg::TDATA_W-1:0]  s_tdata,   // address, length, payload, zero pad
    input  logic [1:0]                   s_tuser,   // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sac_pkg::TDATA_W-1:0]  m_tdata,   // mem_address, mem_length, result_data, zero pad
    output logic [1:0]                   m_tuser,   // kind
    output logic                         m_tlast,
    input  logic                         cfg_wr_en,
    input  logic [15:0]                  cfg_wr_data
);

    sac_pkg::result_t res;
    sac_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             out_space;

    assign out_space = !out_valid_reg || m_tready;

    sac_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_space   (out_space),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.data, out_reg.len, out_reg.addr};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule
